/* rtl/swpm_pkg.sv */
// shared types, constants and lookup functions of the sliding-window power meter
// no dependencies; every other file but swpm_ram imports this package
package swpm_pkg;

	localparam int SAMPLE_BITS     = 16;
	localparam int WINDOW_MAX_DEF  = 1024;
	localparam int WS_BITS         = 11;
	localparam int TIME_BITS       = 64;
	localparam int SUM_SQ_BITS     = 41;
	localparam int SUM_UI_BITS     = 42;
	localparam int MUL_OP_BITS     = 42;
	localparam int MUL_HALF        = 21;
	localparam int PROD_BITS       = 84;
	localparam int ROOT_BITS       = 42;
	localparam int SQ_REM_BITS     = 46;
	localparam int CORDIC_STEPS    = 16;
	localparam int CXY_BITS        = 35;
	localparam int Z_BITS          = 20;
	localparam int ZPOS_BITS       = 19;
	localparam int DEG_BITS        = 22;
	localparam int ANGLE_BITS      = 15;
	localparam int ACTIVE_BITS     = 32;
	localparam int MAG_BITS        = 31;
	localparam int CFG_IDX_BITS    = 2;
	localparam int CFG_DATA_BITS   = 11;
	localparam int STEP_BITS       = 6;
	localparam int MAC_STEPS       = 6;
	localparam int MUL_STEPS       = 4;
	localparam int SQ_STEPS        = 42;
	localparam int DIV_STEPS       = 42;
	localparam int HALF_PI_Q16     = 102944;
	localparam int DEG_PER_RAD_Q16 = 3754936;
	localparam int ANGLE_SAT       = 32767;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_BITS-1:0] CFG_WIN_LEN    = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ANG_UNIT   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TIME_ALIGN = 2'd2;

	// timestamp alignment codes, anything else means center
	localparam logic [1:0] ALIGN_OLDEST = 2'd0;
	localparam logic [1:0] ALIGN_NEWEST = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE, ST_READ, ST_MAC, ST_WRITE, ST_SLOT, ST_MUL_UU, ST_MUL_UI, ST_RAD,
		ST_SQ_LOAD, ST_SQ_STEP, ST_DIV_LOAD, ST_DIV_STEP, ST_DIV_STORE,
		ST_CORDIC_LOAD, ST_CORDIC_STEP, ST_ANGLE, ST_OUT
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_READ_OLD, OP_MAC, OP_WRITE, OP_READ_SLOT, OP_MUL_UU,
		OP_MUL_UI, OP_RAD, OP_SQ_LOAD, OP_SQ_STEP, OP_DIV_LOAD, OP_DIV_STEP,
		OP_DIV_STORE, OP_CORDIC_LOAD, OP_CORDIC_STEP, OP_ANGLE, OP_OUT
	} op_t;

	typedef enum logic [1:0] {
		PASS_APPARENT, PASS_REACTIVE, PASS_ACTIVE
	} pass_t;

	typedef struct packed {
		op_t                  op;
		logic [STEP_BITS-1:0] step;
		pass_t                pass;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic out_busy;
	} stat_t;

	// arctangent of 2^-k in radians, Q.16
	function automatic logic [15:0] atan_q16(input logic [3:0] k);
		logic [15:0] v;
		case (k)
			4'd0:    v = 16'd51472;
			4'd1:    v = 16'd30386;
			4'd2:    v = 16'd16055;
			4'd3:    v = 16'd8150;
			4'd4:    v = 16'd4091;
			4'd5:    v = 16'd2047;
			4'd6:    v = 16'd1024;
			4'd7:    v = 16'd512;
			4'd8:    v = 16'd256;
			4'd9:    v = 16'd128;
			4'd10:   v = 16'd64;
			4'd11:   v = 16'd32;
			4'd12:   v = 16'd16;
			4'd13:   v = 16'd8;
			4'd14:   v = 16'd4;
			default: v = 16'd2;
		endcase
		return v;
	endfunction

endpackage

/* rtl/swpm_if.sv */
// valid/ready channel interfaces of the power meter: samples, results, config writes
// depends on swpm_pkg for the payload widths
interface swpm_in_if import swpm_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] voltage;
	logic signed [SAMPLE_BITS-1:0] current;
	logic [TIME_BITS-1:0]          sample_time;

	modport source (output valid, voltage, current, sample_time, input ready);
	modport sink (input valid, voltage, current, sample_time, output ready);
endinterface

interface swpm_out_if import swpm_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [ACTIVE_BITS-1:0] p_active;
	logic [MAG_BITS-1:0]           q_reactive;
	logic [MAG_BITS-1:0]           s_apparent;
	logic [ANGLE_BITS-1:0]         phase_angle;
	logic [TIME_BITS-1:0]          result_time;

	modport source (output valid, p_active, q_reactive, s_apparent,
		phase_angle, result_time, input ready);
	modport sink (input valid, p_active, q_reactive, s_apparent,
		phase_angle, result_time, output ready);
endinterface

interface swpm_cfg_if import swpm_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/swpm_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module swpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/swpm_ctrl.sv */
// sequencer of the power meter: steps the datapath through one item
// depends on swpm_pkg (state, command and status types)
module swpm_ctrl import swpm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t               state_q, state_d;
	logic [STEP_BITS-1:0] step_q;
	pass_t                pass_q;

	function automatic logic is_last(input logic [STEP_BITS-1:0] s, input int n);
		return s == STEP_BITS'(n - 1);
	endfunction

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:        if (in_valid) state_d = ST_READ;
			ST_READ:        state_d = ST_MAC;
			ST_MAC:         if (is_last(step_q, MAC_STEPS)) state_d = ST_WRITE;
			ST_WRITE:       state_d = stat.full ? ST_SLOT : ST_IDLE;
			ST_SLOT:        state_d = ST_MUL_UU;
			ST_MUL_UU:      if (is_last(step_q, MUL_STEPS)) state_d = ST_MUL_UI;
			ST_MUL_UI:      if (is_last(step_q, MUL_STEPS)) state_d = ST_RAD;
			ST_RAD:         state_d = ST_SQ_LOAD;
			ST_SQ_LOAD:     state_d = ST_SQ_STEP;
			ST_SQ_STEP:     if (is_last(step_q, SQ_STEPS)) state_d = ST_DIV_LOAD;
			ST_DIV_LOAD:    state_d = ST_DIV_STEP;
			ST_DIV_STEP:    if (is_last(step_q, DIV_STEPS)) state_d = ST_DIV_STORE;
			ST_DIV_STORE: begin
				unique case (pass_q)
					PASS_APPARENT: state_d = ST_SQ_LOAD;
					PASS_REACTIVE: state_d = ST_DIV_LOAD;
					default:       state_d = ST_CORDIC_LOAD;
				endcase
			end
			ST_CORDIC_LOAD: state_d = ST_CORDIC_STEP;
			ST_CORDIC_STEP: if (is_last(step_q, CORDIC_STEPS)) state_d = ST_ANGLE;
			ST_ANGLE:       state_d = ST_OUT;
			ST_OUT:         if (!stat.out_busy) state_d = ST_IDLE;
			default:        state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		cmd.step = step_q;
		cmd.pass = pass_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.op   = in_valid ? OP_LOAD : OP_NONE;
			end
			ST_READ:        cmd.op = OP_READ_OLD;
			ST_MAC:         cmd.op = OP_MAC;
			ST_WRITE:       cmd.op = OP_WRITE;
			ST_SLOT:        cmd.op = OP_READ_SLOT;
			ST_MUL_UU:      cmd.op = OP_MUL_UU;
			ST_MUL_UI:      cmd.op = OP_MUL_UI;
			ST_RAD:         cmd.op = OP_RAD;
			ST_SQ_LOAD:     cmd.op = OP_SQ_LOAD;
			ST_SQ_STEP:     cmd.op = OP_SQ_STEP;
			ST_DIV_LOAD:    cmd.op = OP_DIV_LOAD;
			ST_DIV_STEP:    cmd.op = OP_DIV_STEP;
			ST_DIV_STORE:   cmd.op = OP_DIV_STORE;
			ST_CORDIC_LOAD: cmd.op = OP_CORDIC_LOAD;
			ST_CORDIC_STEP: cmd.op = OP_CORDIC_STEP;
			ST_ANGLE:       cmd.op = OP_ANGLE;
			ST_OUT:         cmd.op = stat.out_busy ? OP_NONE : OP_OUT;
			default:        cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			pass_q  <= PASS_APPARENT;
		end else begin
			state_q <= state_d;
			step_q  <= (state_d == state_q) ? step_q + 1'b1 : '0;
			if (state_q == ST_IDLE) begin
				pass_q <= PASS_APPARENT;
			end else if (state_q == ST_DIV_STORE) begin
				pass_q <= (pass_q == PASS_APPARENT) ? PASS_REACTIVE : PASS_ACTIVE;
			end
		end
	end

endmodule

/* rtl/swpm_dp.sv */
// datapath of the power meter: config registers, history ram, running sums,
// shared multiplier, bit-serial root and divider, cordic and output register
// depends on swpm_pkg and swpm_ram
module swpm_dp import swpm_pkg::*; #(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmd_t                          cmd,
	output stat_t                         stat,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [CFG_DATA_BITS-1:0]      cfg_data,
	input  logic signed [SAMPLE_BITS-1:0] voltage,
	input  logic signed [SAMPLE_BITS-1:0] current,
	input  logic [TIME_BITS-1:0]          sample_time,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic signed [ACTIVE_BITS-1:0] p_active,
	output logic [MAG_BITS-1:0]           q_reactive,
	output logic [MAG_BITS-1:0]           s_apparent,
	output logic [ANGLE_BITS-1:0]         phase_angle,
	output logic [TIME_BITS-1:0]          result_time
);

	localparam int AW     = $clog2(WINDOW_MAX);
	localparam int RAM_W  = 2 * SAMPLE_BITS + TIME_BITS;

	// configuration and window state
	logic [WS_BITS-1:0]            ws_q;
	logic                          unit_q;
	logic [1:0]                    align_q;
	logic [WS_BITS-1:0]            wp_q, fc_q, pos_q;
	logic                          full_q;
	logic [SUM_SQ_BITS-1:0]        suu_q, sii_q;
	logic signed [SUM_UI_BITS-1:0] sui_q;

	// item and arithmetic registers
	logic signed [SAMPLE_BITS-1:0] u_q, i_q;
	logic [TIME_BITS-1:0]          t_q;
	logic [PROD_BITS-1:0]          prod_a_q, prod_b_q, sq_n_q;
	logic [SQ_REM_BITS-1:0]        sq_rem_q;
	logic [ROOT_BITS-1:0]          sq_root_q;
	logic [MUL_OP_BITS-1:0]        div_n_q;
	logic [WS_BITS-1:0]            div_rem_q;
	logic [ACTIVE_BITS-1:0]        s_val_q, q_val_q;
	logic signed [ACTIVE_BITS-1:0] p_val_q;
	logic signed [CXY_BITS-1:0]    cx_q, cy_q;
	logic signed [Z_BITS-1:0]      cz_q;
	logic [ZPOS_BITS-1:0]          zr_q;
	logic [ZPOS_BITS+DEG_BITS-1:0] deg_prod_q;
	logic                          out_valid_q;

	// window length, 0 acts as 1, clipped to the ring depth
	logic [WS_BITS-1:0] w, half_w;
	always_comb begin
		if (ws_q == '0) begin
			w = WS_BITS'(1);
		end else if (32'(ws_q) > 32'(WINDOW_MAX)) begin
			w = WS_BITS'(WINDOW_MAX);
		end else begin
			w = ws_q;
		end
		half_w = w >> 1;
	end

	// next write slot, also the oldest sample; center slot
	logic [WS_BITS-1:0] nxt_pos, slot;
	logic [WS_BITS:0]   ctr_sum;
	always_comb begin
		nxt_pos = (pos_q + 1'b1 == w) ? '0 : pos_q + 1'b1;
		ctr_sum = {1'b0, pos_q} + {1'b0, w - half_w};
		case (align_q)
			ALIGN_OLDEST: slot = nxt_pos;
			ALIGN_NEWEST: slot = pos_q;
			default:      slot = (ctr_sum >= {1'b0, w}) ? WS_BITS'(ctr_sum - {1'b0, w})
			                                            : WS_BITS'(ctr_sum);
		endcase
	end

	// history ram: voltage, current, timestamp
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [RAM_W-1:0] ram_rdata;
	assign ram_re    = (cmd.op == OP_READ_OLD) || (cmd.op == OP_READ_SLOT);
	assign ram_raddr = (cmd.op == OP_READ_SLOT) ? AW'(slot) : AW'(pos_q);

	swpm_ram #(.WIDTH(RAM_W), .DEPTH(WINDOW_MAX)) u_hist (
		.clk   (clk),
		.we    (cmd.op == OP_WRITE),
		.waddr (AW'(pos_q)),
		.wdata ({u_q, i_q, t_q}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// slot not yet written since the window started reads as zero
	logic signed [SAMPLE_BITS-1:0] old_u, old_i;
	assign old_u = full_q ? $signed(ram_rdata[RAM_W-1 -: SAMPLE_BITS]) : '0;
	assign old_i = full_q ? $signed(ram_rdata[TIME_BITS +: SAMPLE_BITS]) : '0;

	// shared 16x16 multiply-accumulate for the running sums
	logic signed [SAMPLE_BITS-1:0]   mac_a, mac_b;
	logic signed [2*SAMPLE_BITS-1:0] mac_p;
	logic [SUM_UI_BITS-1:0]          mac_ext;
	logic                            mac_sub;
	logic [1:0]                      mac_tgt;
	always_comb begin
		mac_a   = u_q;
		mac_b   = u_q;
		mac_sub = cmd.step[0];
		mac_tgt = 2'd0;
		case (cmd.step)
			6'd0: begin mac_a = u_q;   mac_b = u_q;   mac_tgt = 2'd0; end
			6'd1: begin mac_a = old_u; mac_b = old_u; mac_tgt = 2'd0; end
			6'd2: begin mac_a = i_q;   mac_b = i_q;   mac_tgt = 2'd1; end
			6'd3: begin mac_a = old_i; mac_b = old_i; mac_tgt = 2'd1; end
			6'd4: begin mac_a = u_q;   mac_b = i_q;   mac_tgt = 2'd2; end
			default: begin mac_a = old_u; mac_b = old_i; mac_tgt = 2'd2; end
		endcase
		mac_p   = mac_a * mac_b;
		mac_ext = {{(SUM_UI_BITS-2*SAMPLE_BITS){mac_p[2*SAMPLE_BITS-1]}}, mac_p};
	end

	// magnitude of the cross sum
	logic [MUL_OP_BITS-1:0] mag;
	assign mag = sui_q[SUM_UI_BITS-1] ? MUL_OP_BITS'(-sui_q) : MUL_OP_BITS'(sui_q);

	// 42x42 product as four 21x21 partial products
	logic [MUL_OP_BITS-1:0] mul_a, mul_b;
	logic [MUL_HALF-1:0]    mul_ah, mul_bh;
	logic [2*MUL_HALF-1:0]  mul_pp;
	logic [PROD_BITS-1:0]   mul_sh, mul_acc;
	always_comb begin
		mul_a  = (cmd.op == OP_MUL_UU) ? MUL_OP_BITS'(suu_q) : mag;
		mul_b  = (cmd.op == OP_MUL_UU) ? MUL_OP_BITS'(sii_q) : mag;
		mul_ah = cmd.step[0] ? mul_a[MUL_OP_BITS-1 -: MUL_HALF] : mul_a[MUL_HALF-1:0];
		mul_bh = cmd.step[1] ? mul_b[MUL_OP_BITS-1 -: MUL_HALF] : mul_b[MUL_HALF-1:0];
		mul_pp = mul_ah * mul_bh;
		case (cmd.step[1:0])
			2'd0:    mul_sh = PROD_BITS'(mul_pp);
			2'd3:    mul_sh = PROD_BITS'(mul_pp) << (2 * MUL_HALF);
			default: mul_sh = PROD_BITS'(mul_pp) << MUL_HALF;
		endcase
		mul_acc = (cmd.step == '0) ? '0 : ((cmd.op == OP_MUL_UU) ? prod_a_q : prod_b_q);
	end

	// one digit of the integer square root
	logic [SQ_REM_BITS-1:0] sq_sh, sq_trial;
	logic                   sq_ge;
	always_comb begin
		sq_sh    = {sq_rem_q[SQ_REM_BITS-3:0], sq_n_q[PROD_BITS-1 -: 2]};
		sq_trial = SQ_REM_BITS'({sq_root_q, 2'b01});
		sq_ge    = sq_sh >= sq_trial;
	end

	// one bit of the division by the window length
	logic [WS_BITS:0] div_sh;
	logic             div_ge;
	always_comb begin
		div_sh = {div_rem_q, div_n_q[MUL_OP_BITS-1]};
		div_ge = div_sh >= {1'b0, w};
	end

	// cordic inputs and one rotation
	logic signed [CXY_BITS-1:0] p_ext, q_ext, c_dx, c_dy;
	logic signed [Z_BITS-1:0]   c_t;
	always_comb begin
		p_ext = CXY_BITS'(p_val_q);
		q_ext = $signed({{(CXY_BITS-ACTIVE_BITS){1'b0}}, q_val_q});
		c_dx  = cy_q >>> cmd.step[3:0];
		c_dy  = cx_q >>> cmd.step[3:0];
		c_t   = $signed({{(Z_BITS-16){1'b0}}, atan_q16(cmd.step[3:0])});
	end

	// angle scaling and saturation
	logic [ZPOS_BITS:0]              rad_sum;
	logic [ZPOS_BITS+DEG_BITS:0]     deg_sum;
	logic [ZPOS_BITS+DEG_BITS-24:0]  ang_raw;
	logic [ANGLE_BITS-1:0]           ang;
	always_comb begin
		rad_sum = {1'b0, zr_q} + (ZPOS_BITS+1)'(4);
		deg_sum = {1'b0, deg_prod_q} + ((ZPOS_BITS+DEG_BITS+1)'(1) << 24);
		if (unit_q) begin
			ang_raw = (ZPOS_BITS+DEG_BITS-23)'(deg_sum >> 25);
		end else begin
			ang_raw = (ZPOS_BITS+DEG_BITS-23)'(rad_sum >> 3);
		end
		ang = (ang_raw > (ZPOS_BITS+DEG_BITS-23)'(ANGLE_SAT)) ? ANGLE_BITS'(ANGLE_SAT)
		                                                     : ANGLE_BITS'(ang_raw);
	end

	// control state: config, ring pointers, sums, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q        <= WS_BITS'(1);
			unit_q      <= 1'b0;
			align_q     <= 2'd1;
			wp_q        <= '0;
			fc_q        <= '0;
			suu_q       <= '0;
			sii_q       <= '0;
			sui_q       <= '0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_WIN_LEN: begin
						ws_q  <= cfg_data;
						wp_q  <= '0;
						fc_q  <= '0;
						suu_q <= '0;
						sii_q <= '0;
						sui_q <= '0;
					end
					CFG_ANG_UNIT:   unit_q  <= cfg_data[0];
					CFG_TIME_ALIGN: align_q <= cfg_data[1:0];
					default: ;
				endcase
			end
			if (cmd.op == OP_LOAD) begin
				full_q <= fc_q >= w;
			end
			if (cmd.op == OP_MAC) begin
				case (mac_tgt)
					2'd0: suu_q <= mac_sub ? suu_q - SUM_SQ_BITS'(mac_ext)
					                       : suu_q + SUM_SQ_BITS'(mac_ext);
					2'd1: sii_q <= mac_sub ? sii_q - SUM_SQ_BITS'(mac_ext)
					                       : sii_q + SUM_SQ_BITS'(mac_ext);
					default: sui_q <= mac_sub ? sui_q - $signed(mac_ext)
					                          : sui_q + $signed(mac_ext);
				endcase
			end
			if (cmd.op == OP_WRITE) begin
				wp_q <= nxt_pos;
				if (fc_q < w) begin
					fc_q <= fc_q + 1'b1;
				end
			end
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// arithmetic registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				u_q   <= voltage;
				i_q   <= current;
				t_q   <= sample_time;
				pos_q <= (wp_q < w) ? wp_q : '0;
			end
			OP_MUL_UU: prod_a_q <= mul_acc + mul_sh;
			OP_MUL_UI: prod_b_q <= mul_acc + mul_sh;
			OP_RAD: prod_b_q <= (prod_b_q > prod_a_q) ? '0 : prod_a_q - prod_b_q;
			OP_SQ_LOAD: begin
				sq_n_q    <= (cmd.pass == PASS_REACTIVE) ? prod_b_q : prod_a_q;
				sq_rem_q  <= '0;
				sq_root_q <= '0;
			end
			OP_SQ_STEP: begin
				sq_n_q    <= sq_n_q << 2;
				sq_rem_q  <= sq_ge ? sq_sh - sq_trial : sq_sh;
				sq_root_q <= {sq_root_q[ROOT_BITS-2:0], sq_ge};
			end
			OP_DIV_LOAD: begin
				div_n_q   <= ((cmd.pass == PASS_ACTIVE) ? mag : sq_root_q)
				             + MUL_OP_BITS'(half_w);
				div_rem_q <= '0;
			end
			OP_DIV_STEP: begin
				div_rem_q <= div_ge ? WS_BITS'(div_sh - {1'b0, w}) : WS_BITS'(div_sh);
				div_n_q   <= {div_n_q[MUL_OP_BITS-2:0], div_ge};
			end
			OP_DIV_STORE: begin
				case (cmd.pass)
					PASS_APPARENT: s_val_q <= ACTIVE_BITS'(div_n_q);
					PASS_REACTIVE: q_val_q <= ACTIVE_BITS'(div_n_q);
					default: p_val_q <= sui_q[SUM_UI_BITS-1] ? -$signed(ACTIVE_BITS'(div_n_q))
					                                        : $signed(ACTIVE_BITS'(div_n_q));
				endcase
			end
			OP_CORDIC_LOAD: begin
				if (p_val_q < 0) begin
					cx_q <= q_ext;
					cy_q <= -p_ext;
					cz_q <= Z_BITS'(HALF_PI_Q16);
				end else begin
					cx_q <= p_ext;
					cy_q <= q_ext;
					cz_q <= '0;
				end
			end
			OP_CORDIC_STEP: begin
				if (cy_q > 0) begin
					cx_q <= cx_q + c_dx;
					cy_q <= cy_q - c_dy;
					cz_q <= cz_q + c_t;
				end else if (cy_q < 0) begin
					cx_q <= cx_q - c_dx;
					cy_q <= cy_q + c_dy;
					cz_q <= cz_q - c_t;
				end
			end
			OP_ANGLE: begin
				zr_q       <= cz_q[Z_BITS-1] ? '0 : ZPOS_BITS'(cz_q);
				deg_prod_q <= (cz_q[Z_BITS-1] ? '0 : ZPOS_BITS'(cz_q))
				              * DEG_BITS'(DEG_PER_RAD_Q16);
			end
			OP_OUT: begin
				p_active    <= p_val_q;
				q_reactive  <= MAG_BITS'(q_val_q);
				s_apparent  <= MAG_BITS'(s_val_q);
				phase_angle <= ang;
				result_time <= ram_rdata[TIME_BITS-1:0];
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign stat.full     = full_q;
	assign stat.out_busy = out_valid_q && !out_ready;

endmodule

/* rtl/sliding_window_power_meter.sv */
// top level of the sliding-window power meter
// depends on swpm_pkg, swpm_if, swpm_ctrl, swpm_dp and swpm_ram
//
// usage
//  - samples: one beat carries a voltage/current pair (signed Q1.15) and a
//    64-bit timestamp; ready is high only while the sequencer is idle
//  - results: one beat per sample once the window is full, carrying active
//    power P (Q2.30), reactive Q, apparent S, the angle atan2(Q,P) and a
//    timestamp from the oldest, center or newest window slot
//  - cfg: register writes (0 window length, 1 angle unit, 2 timestamp
//    alignment), always ready; write only while idle; a window length write
//    restarts the window
//  - processing: a sample that gives no result runs a history read, six
//    multiply-accumulate steps on one 16x16 multiplier and a ring write; a
//    sample with a result adds the two 42-step square roots, three 42-step
//    divisions by the window length and the 16-step cordic, all bit-serial;
//    no new sample is taken until the sequencer is back in idle
//  - the result sits in an output register; a new sample is taken while it
//    waits, and a stalled receiver only holds the sequencer at its last step
//  - reset: empty window, sums zero, window length 1, radians, center timestamp;
//    the history ram needs no clearing since a fill count masks unwritten slots
module sliding_window_power_meter import swpm_pkg::*; #(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
	input logic        clk,
	input logic        arst_n,
	swpm_in_if.sink    samples,
	swpm_out_if.source results,
	swpm_cfg_if.sink   cfg
);

	cmd_t  cmd;
	stat_t stat;

	// config writes never stall
	assign cfg.ready = 1'b1;

	swpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	swpm_dp #(.WINDOW_MAX(WINDOW_MAX)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.voltage     (samples.voltage),
		.current     (samples.current),
		.sample_time (samples.sample_time),
		.out_ready   (results.ready),
		.out_valid   (results.valid),
		.p_active    (results.p_active),
		.q_reactive  (results.q_reactive),
		.s_apparent  (results.s_apparent),
		.phase_angle (results.phase_angle),
		.result_time (results.result_time)
	);

endmodule

/* rtl/swpm_checker.sv */
// port-level checks of the power meter, bound to the top level
// depends on swpm_pkg and sliding_window_power_meter
module swpm_checker import swpm_pkg::*; (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [ACTIVE_BITS-1:0] p_active,
	input logic [MAG_BITS-1:0]           q_reactive,
	input logic [MAG_BITS-1:0]           s_apparent,
	input logic [ANGLE_BITS-1:0]         phase_angle,
	input logic [TIME_BITS-1:0]          result_time
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({p_active, q_reactive,
			s_apparent, phase_angle, result_time}))
		else $error("result payload changed while stalled");

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken while previous one still in work");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared right after a sample beat");

	a_q_le_s: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> q_reactive <= s_apparent)
		else $error("reactive power above apparent power");

endmodule

bind sliding_window_power_meter swpm_checker u_swpm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (samples.valid),
	.in_ready    (samples.ready),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.p_active    (results.p_active),
	.q_reactive  (results.q_reactive),
	.s_apparent  (results.s_apparent),
	.phase_angle (results.phase_angle),
	.result_time (results.result_time)
);
